/* rtl/url_percent_codec_defines.svh */
// Assertion macros shared by the RTL of the URL percent codec.
// Each macro expands to one labeled concurrent assertion on clk with arst_n.
`ifndef URL_PERCENT_CODEC_DEFINES_SVH
`define URL_PERCENT_CODEC_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/upc_pkg.sv */
// Package of the URL percent codec: payload structs, escape phase type,
// character constants, character class and hex helpers. No dependencies.
package upc_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_in_run;
		logic       message_done;
	} result_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	localparam logic       MODE_ENCODE = 1'b0;
	localparam logic [7:0] CH_PCT      = 8'h25;
	localparam logic [7:0] CH_DASH     = 8'h2D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_USCORE   = 8'h5F;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_UP_A     = 8'h41;
	localparam logic [7:0] CH_UP_F     = 8'h46;
	localparam logic [7:0] CH_UP_Z     = 8'h5A;
	localparam logic [7:0] CH_LO_A     = 8'h61;
	localparam logic [7:0] CH_LO_F     = 8'h66;
	localparam logic [7:0] CH_LO_Z     = 8'h7A;
	localparam logic [3:0] NIB_NINE    = 4'h9;
	localparam logic [7:0] NIB_TEN     = 8'h0A;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_unreserved(input logic [7:0] b);
		return is_digit(b) || ((b >= CH_UP_A) && (b <= CH_UP_Z)) ||
			((b >= CH_LO_A) && (b <= CH_LO_Z)) ||
			(b == CH_DASH) || (b == CH_DOT) || (b == CH_USCORE);
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || ((b >= CH_UP_A) && (b <= CH_UP_F)) ||
			((b >= CH_LO_A) && (b <= CH_LO_F));
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] b);
		logic [7:0] v;
		v = 8'h00;
		if (is_digit(b)) begin
			v = b - CH_ZERO;
		end else if ((b >= CH_UP_A) && (b <= CH_UP_F)) begin
			v = b - CH_UP_A + NIB_TEN;
		end else if ((b >= CH_LO_A) && (b <= CH_LO_F)) begin
			v = b - CH_LO_A + NIB_TEN;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib > NIB_NINE) ? (CH_UP_A + {4'h0, nib} - NIB_TEN) : (CH_ZERO + {4'h0, nib});
	endfunction

endpackage

/* rtl/url_percent_codec.sv */
// Top level of the URL percent codec: byte classification, escape tracking,
// run register and output register. Depends on upc_pkg and the defines header.
//
// Usage: bytes enter on the item channel (item_valid, item_stall, item) and
// results leave on the result channel (result_valid, result_stall, result);
// a transfer happens at a clock edge where valid is high and stall is low.
// The mode channel (mode_valid, mode_ready, mode_data) selects encoding (0)
// or decoding (1) and drops any held escape bytes; mode_ready is always high.
// The user must issue mode transfers only while the codec is idle (unenforced).
// An accepted byte produces zero to three results. They are placed in a run
// register in the cycle of the transfer and then moved to the output register
// one per cycle while the receiver does not stall; each result passes through
// the run register and then the output register. A byte's run holds the run
// register until its last result moves out, so the input rate is one byte per
// cycle for plain text while the receiver does not stall, and escaped bytes in
// encode mode, with three results each, are taken more slowly; the single
// output register port sets the rate. A new byte is taken in the cycle the
// last result of the previous run moves out. When the receiver stalls, the
// output register holds its result and the run register and input back up.
// Reset selects encode mode and clears all valid flags and the escape state.
`include "url_percent_codec_defines.svh"

module url_percent_codec (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  upc_pkg::item_t   item,
	output logic            result_valid,
	input  logic            result_stall,
	output upc_pkg::result_t result,
	input  logic            mode_valid,
	output logic            mode_ready,
	input  logic            mode_data
);
	import upc_pkg::*;

	logic       mode_q;
	phase_t     phase_q;
	phase_t     phase_next;
	logic [7:0] held_q;
	logic [7:0] held_next;

	logic       run_valid_s1;
	logic [1:0] run_idx_s1;
	logic [1:0] run_cnt_s1;
	logic       run_eom_s1;
	logic [7:0] run_bytes_s1 [3];

	logic       res_valid_s2;
	result_t    res_data_s2;

	logic [7:0] emit_bytes [3];
	logic [1:0] emit_cnt;
	logic       b_hex;
	logic       fresh_emit;
	logic       out_load;
	logic       move;
	logic       run_last;
	logic       accept;
	logic [7:0] in_b;
	logic       in_eom;

	assign in_b       = item.data_byte;
	assign in_eom     = item.end_of_message;
	assign b_hex      = is_hex(in_b);
	assign fresh_emit = !((in_b == CH_PCT) && !in_eom);

	always_comb begin
		phase_next = phase_q;
		held_next  = held_q;
		if (mode_q != MODE_ENCODE) begin
			unique case (phase_q)
				PH_PCT: begin
					if (b_hex && !in_eom) begin
						phase_next = PH_DIGIT;
						held_next  = in_b;
					end else begin
						phase_next = (b_hex || fresh_emit) ? PH_IDLE : PH_PCT;
					end
				end
				default: begin
					phase_next = fresh_emit ? PH_IDLE : PH_PCT;
				end
			endcase
		end
	end

	always_comb begin
		emit_bytes[0] = in_b;
		emit_bytes[1] = in_b;
		emit_bytes[2] = in_b;
		emit_cnt      = 2'd0;
		if (mode_q == MODE_ENCODE) begin
			if (is_unreserved(in_b)) begin
				emit_cnt = 2'd1;
			end else begin
				emit_bytes[0] = CH_PCT;
				emit_bytes[1] = hex_char(in_b[7:4]);
				emit_bytes[2] = hex_char(in_b[3:0]);
				emit_cnt      = 2'd3;
			end
		end else begin
			unique case (phase_q)
				PH_PCT: begin
					emit_bytes[0] = CH_PCT;
					if (b_hex) begin
						emit_cnt = in_eom ? 2'd2 : 2'd0;
					end else begin
						emit_cnt = fresh_emit ? 2'd2 : 2'd1;
					end
				end
				PH_DIGIT: begin
					if (b_hex) begin
						emit_bytes[0] = {hex_value(held_q), hex_value(in_b)};
						emit_cnt      = 2'd1;
					end else begin
						emit_bytes[0] = CH_PCT;
						emit_bytes[1] = held_q;
						emit_cnt      = fresh_emit ? 2'd3 : 2'd2;
					end
				end
				default: begin
					emit_cnt = fresh_emit ? 2'd1 : 2'd0;
				end
			endcase
		end
	end

	assign out_load     = !res_valid_s2 || !result_stall;
	assign move         = run_valid_s1 && out_load;
	assign run_last     = (run_idx_s1 == (run_cnt_s1 - 2'd1));
	assign item_stall   = run_valid_s1 && !(move && run_last);
	assign accept       = item_valid && !item_stall;
	assign mode_ready   = 1'b1;
	assign result_valid = res_valid_s2;
	assign result       = res_data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_ENCODE;
			phase_q      <= PH_IDLE;
			run_valid_s1 <= 1'b0;
			run_idx_s1   <= 2'd0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (mode_valid) begin
				mode_q  <= mode_data;
				phase_q <= PH_IDLE;
			end else if (accept) begin
				phase_q <= phase_next;
			end
			if (accept) begin
				run_valid_s1 <= (emit_cnt != 2'd0);
				run_idx_s1   <= 2'd0;
			end else if (move) begin
				if (run_last) begin
					run_valid_s1 <= 1'b0;
				end else begin
					run_idx_s1 <= run_idx_s1 + 2'd1;
				end
			end
			if (out_load) begin
				res_valid_s2 <= move;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !mode_valid) begin
			held_q <= held_next;
		end
		if (accept) begin
			run_bytes_s1 <= emit_bytes;
			run_cnt_s1   <= emit_cnt;
			run_eom_s1   <= in_eom;
		end
		if (move) begin
			res_data_s2.out_byte     <= run_bytes_s1[run_idx_s1];
			res_data_s2.last_in_run  <= run_last;
			res_data_s2.message_done <= run_last && run_eom_s1;
		end
	end

	`UPC_ASSERT_NOW(a_run_nonempty, run_valid_s1, run_cnt_s1 != 2'd0,
		"run register holds an empty run")
	`UPC_ASSERT_NOW(a_run_index, run_valid_s1, run_idx_s1 < run_cnt_s1,
		"run index beyond run length")
	`UPC_ASSERT_NEXT(a_mode_clears, mode_valid, phase_q == PH_IDLE,
		"mode transfer did not clear the escape state")
	`UPC_ASSERT_NEXT(a_done_ends_run, move && run_last && run_eom_s1,
		res_valid_s2 && res_data_s2.message_done && res_data_s2.last_in_run,
		"message end not marked on last result")

endmodule
